// ===== rtl/core/dta_pkg.sv =====
`default_nettype none
package dta_pkg;

  localparam int MAX_SLOTS          = 256;
  localparam int RESERVED_SLOTS     = 3;
  localparam int SYSTEM_DESCRIPTORS = 1024;

  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int LIM_W     = SLOT_W + 1;
  localparam int SYS_W     = 11;
  localparam int ROW_W     = 32;
  localparam int ROW_BIT_W = $clog2(ROW_W);
  localparam int ROWS      = MAX_SLOTS / ROW_W;
  localparam int ROW_IDX_W = SLOT_W - ROW_BIT_W;

  typedef logic [2:0]                op_t;
  typedef logic [SLOT_W-1:0]         slot_t;
  typedef logic [LIM_W-1:0]          lim_t;
  typedef logic signed [SYS_W-1:0]   sysd_t;
  typedef logic [1:0]                status_t;
  typedef logic [ROW_W-1:0]          row_t;
  typedef logic [ROW_IDX_W-1:0]      row_idx_t;
  typedef logic [ROW_BIT_W-1:0]      bit_idx_t;

  typedef struct packed {
    logic     found;
    bit_idx_t pos;
  } find_t;

  localparam op_t OP_CHECK      = 3'd0;
  localparam op_t OP_ASSOC      = 3'd1;
  localparam op_t OP_LOOKUP     = 3'd2;
  localparam op_t OP_ALLOC_SPEC = 3'd3;
  localparam op_t OP_FREE       = 3'd4;
  localparam op_t OP_DISASSOC   = 3'd5;
  localparam op_t OP_ALLOC_LOW  = 3'd6;
  localparam op_t OP_ALLOC_BIND = 3'd7;

  localparam status_t STAT_OK   = 2'd0;
  localparam status_t STAT_ERR  = 2'd1;
  localparam status_t STAT_BADF = 2'd2;
  localparam status_t STAT_BUSY = 2'd3;

  localparam sysd_t            SYS_NONE  = sysd_t'(-1);
  localparam logic [SYS_W-1:0] SYS_LIMIT = SYS_W'(SYSTEM_DESCRIPTORS);
  localparam lim_t             LIM_MAX   = LIM_W'(MAX_SLOTS);
  localparam slot_t            SLOT_RES  = SLOT_W'(RESERVED_SLOTS);

endpackage
`default_nettype wire

// ===== rtl/core/dta_in_if.sv =====
`default_nettype none
interface dta_in_if;
  import dta_pkg::*;

  logic  valid;
  logic  ready;
  op_t   operation;
  slot_t slot_index;
  sysd_t system_descriptor;
  slot_t minimum_slot;

  modport source (output valid, output operation, output slot_index,
                  output system_descriptor, output minimum_slot, input ready);
  modport sink (input valid, input operation, input slot_index,
                input system_descriptor, input minimum_slot, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dta_out_if.sv =====
`default_nettype none
interface dta_out_if;
  import dta_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  sysd_t   descriptor_value;

  modport source (output valid, output status, output descriptor_value, input ready);
  modport sink (input valid, input status, input descriptor_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dta_ram.sv =====
`default_nettype none
module dta_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/core/dta_row_find.sv =====
`default_nettype none
module dta_row_find (
  input  dta_pkg::row_t     row_bits,
  input  dta_pkg::row_idx_t row_idx,
  input  dta_pkg::slot_t    min_slot,
  input  dta_pkg::lim_t     lim,
  output dta_pkg::find_t    res
);
  import dta_pkg::*;

  row_t cand;

  // A slot is a candidate when it is free, not below the minimum and below the limit.
  always_comb begin
    for (int i = 0; i < ROW_W; i++) begin
      cand[i] = !row_bits[i]
                && ({1'b0, row_idx, bit_idx_t'(i)} >= {1'b0, min_slot})
                && ({1'b0, row_idx, bit_idx_t'(i)} < lim);
    end
  end

  always_comb begin
    res.found = |cand;
    res.pos   = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        res.pos = bit_idx_t'(i);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/descriptor_table_allocator_core.sv =====
// Slot operations (check, bind, lookup, occupy, free, unbind) read the binding
// and bitmap memories in the transfer cycle; in the execute state, once the output
// register is free, they write back and load the result into the output register.
// Lowest-free allocation scans one 32-slot bitmap row per cycle, from the row of the
// effective minimum slot up to the last row below the limit. Synchronous active-low reset
// clears the per-row and per-slot valid flags, so all slots read free and unbound.
`default_nettype none
module descriptor_table_allocator_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  dta_pkg::lim_t cfg_wdata,
  dta_in_if.sink        in_ch,
  dta_out_if.source     out_ch
);
  import dta_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0] state_r, state_nxt;
  op_t        op_r;
  slot_t      slot_r;
  sysd_t      sys_r;
  slot_t      min_r;
  row_idx_t   row_r, row_nxt;
  lim_t       slots_r;

  logic       out_valid_r;
  status_t    out_status_r;
  sysd_t      out_value_r;

  logic [MAX_SLOTS-1:0] bindv_r;
  logic [ROWS-1:0]      rowv_r;
  logic                 bindv_q_r;
  logic                 rowv_q_r;

  logic       acc;
  logic       alloc_in;
  slot_t      min_eff_in;
  lim_t       lim;
  lim_t       lim_m1;
  row_idx_t   last_row;
  logic       slot_valid;
  logic       sys_ok;
  logic       out_free;

  logic       b_we;
  slot_t      b_waddr;
  sysd_t      b_wdata;
  sysd_t      b_q;
  sysd_t      bd;

  logic       r_we;
  logic       r_re;
  row_idx_t   r_raddr;
  row_t       r_wdata;
  row_t       r_q;
  row_t       rowd;
  row_t       slot_bit;
  logic       occ;
  find_t      fnd;
  slot_t      fnd_slot;
  logic       scan_adv;

  logic       res_load;
  status_t    res_status;
  sysd_t      res_value;

  assign acc        = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign alloc_in   = (in_ch.operation == OP_ALLOC_LOW) || (in_ch.operation == OP_ALLOC_BIND);
  assign min_eff_in = (in_ch.minimum_slot < SLOT_RES) ? SLOT_RES : in_ch.minimum_slot;

  assign lim        = (slots_r > LIM_MAX) ? LIM_MAX : slots_r;
  assign lim_m1     = lim - LIM_W'(1);
  assign last_row   = lim_m1[SLOT_W-1:ROW_BIT_W];
  assign slot_valid = ({1'b0, slot_r} < lim);
  assign sys_ok     = !sys_r[SYS_W-1] && ($unsigned(sys_r) < SYS_LIMIT);
  assign out_free   = !out_valid_r || out_ch.ready;

  assign r_re    = acc || scan_adv;
  assign r_raddr = (state_r == S_IDLE)
                   ? (alloc_in ? min_eff_in[SLOT_W-1:ROW_BIT_W]
                               : in_ch.slot_index[SLOT_W-1:ROW_BIT_W])
                   : row_r + ROW_IDX_W'(1);

  dta_ram #(.DEPTH(MAX_SLOTS), .WIDTH(SYS_W)) u_bind_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .re    (acc),
    .raddr (in_ch.slot_index),
    .rdata (b_q)
  );

  dta_ram #(.DEPTH(ROWS), .WIDTH(ROW_W)) u_bitmap_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (row_r),
    .wdata (r_wdata),
    .re    (r_re),
    .raddr (r_raddr),
    .rdata (r_q)
  );

  assign bd       = bindv_q_r ? b_q : SYS_NONE;
  assign rowd     = rowv_q_r ? r_q : '0;
  assign slot_bit = ROW_W'(1) << slot_r[ROW_BIT_W-1:0];
  assign occ      = rowd[slot_r[ROW_BIT_W-1:0]];

  dta_row_find u_row_find (
    .row_bits (rowd),
    .row_idx  (row_r),
    .min_slot (min_r),
    .lim      (lim),
    .res      (fnd)
  );

  assign fnd_slot = {row_r, fnd.pos};

  always_comb begin
    state_nxt  = state_r;
    row_nxt    = row_r;
    b_we       = 1'b0;
    b_waddr    = slot_r;
    b_wdata    = SYS_NONE;
    r_we       = 1'b0;
    r_wdata    = rowd;
    scan_adv   = 1'b0;
    res_load   = 1'b0;
    res_status = STAT_ERR;
    res_value  = SYS_NONE;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          state_nxt = alloc_in ? S_SCAN : S_EXEC;
          row_nxt   = r_raddr;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
          case (op_r)
            OP_CHECK: begin
              if (slot_valid) begin
                res_status = STAT_OK;
              end
            end
            OP_ASSOC: begin
              if (slot_valid && sys_ok) begin
                b_we       = 1'b1;
                b_wdata    = sys_r;
                res_status = STAT_OK;
                res_value  = sys_r;
              end
            end
            OP_LOOKUP: begin
              if (slot_valid && !bd[SYS_W-1]) begin
                res_status = STAT_OK;
                res_value  = bd;
              end
            end
            OP_ALLOC_SPEC: begin
              if (!slot_valid) begin
                res_status = STAT_BADF;
              end else if (!bd[SYS_W-1]) begin
                b_we       = 1'b1;
                res_status = STAT_OK;
              end else if (occ) begin
                res_status = STAT_BUSY;
              end else begin
                r_we       = 1'b1;
                r_wdata    = rowd | slot_bit;
                res_status = STAT_OK;
              end
            end
            OP_FREE: begin
              if (slot_valid) begin
                b_we       = 1'b1;
                r_we       = 1'b1;
                r_wdata    = rowd & ~slot_bit;
                res_status = STAT_OK;
              end
            end
            OP_DISASSOC: begin
              if (slot_valid && !bd[SYS_W-1]) begin
                b_we       = (slot_r >= SLOT_RES);
                res_status = STAT_OK;
                res_value  = bd;
              end
            end
            default: begin
              res_status = STAT_ERR;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (fnd.found) begin
          if (out_free) begin
            res_load   = 1'b1;
            state_nxt  = S_IDLE;
            r_we       = 1'b1;
            r_wdata    = rowd | (ROW_W'(1) << fnd.pos);
            b_we       = (op_r == OP_ALLOC_BIND);
            b_waddr    = fnd_slot;
            b_wdata    = sys_ok ? sys_r : SYS_NONE;
            res_status = STAT_OK;
            res_value  = sysd_t'({{(SYS_W-SLOT_W){1'b0}}, fnd_slot});
          end
        end else if ((row_r == last_row) || ({1'b0, min_r} >= lim)) begin
          if (out_free) begin
            res_load  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          scan_adv = 1'b1;
          row_nxt  = row_r + ROW_IDX_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slots_r     <= LIM_W'(256);
      out_valid_r <= 1'b0;
      bindv_r     <= '0;
      rowv_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        slots_r <= cfg_wdata;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (b_we) begin
        bindv_r[b_waddr] <= 1'b1;
      end
      if (r_we) begin
        rowv_r[row_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    if (acc) begin
      op_r      <= in_ch.operation;
      slot_r    <= in_ch.slot_index;
      sys_r     <= in_ch.system_descriptor;
      min_r     <= min_eff_in;
      bindv_q_r <= bindv_r[in_ch.slot_index];
    end
    if (r_re) begin
      rowv_q_r <= rowv_r[r_raddr];
    end
    if (res_load) begin
      out_status_r <= res_status;
      out_value_r  <= res_value;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = out_status_r;
  assign out_ch.descriptor_value = out_value_r;

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (state_r != S_IDLE))
    else $error("Engine did not leave idle after an input transfer.");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> ((row_r <= last_row) || ({1'b0, min_r} >= lim)))
    else $error("Bitmap scan went past the last valid row.");

  a_error_value: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && (res_status != STAT_OK)) |-> (res_value == SYS_NONE))
    else $error("An error result carries a value other than none.");

  a_alloc_above_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && (res_status == STAT_OK) && (state_r == S_SCAN))
      |-> (!res_value[SYS_W-1] && (res_value >= SYS_W'(RESERVED_SLOTS))))
    else $error("Allocated slot lies in the reserved range.");

  a_badf_only_specified: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && (res_status == STAT_BADF)) |-> (op_r == OP_ALLOC_SPEC))
    else $error("Bad descriptor status from an operation other than alloc specified.");

endmodule
`default_nettype wire

// ===== tb/descriptor_table_allocator_core_tb.sv =====
`timescale 1ns / 1ps
module descriptor_table_allocator_core_tb;
  import dta_pkg::*;

  localparam int SETTLE_CYCLES  = 12;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 150;
  localparam int PHASES         = 5;

  typedef struct packed {
    op_t   op;
    slot_t slot;
    sysd_t sys;
    slot_t min_slot;
  } desc_request_t;

  typedef struct packed {
    status_t status;
    sysd_t   value;
  } slot_result_t;

  typedef struct packed {
    logic          is_limit;
    lim_t          limit;
    desc_request_t req;
    logic          known;
    slot_result_t  result;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  lim_t cfg_wdata;

  dta_in_if  in_ch ();
  dta_out_if out_ch ();

  descriptor_table_allocator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #1 clk = ~clk;

  logic         slot_taken [MAX_SLOTS];
  sysd_t        slot_binding [MAX_SLOTS];
  lim_t         slot_limit;
  slot_result_t pending_results [$];
  plan_row_t    directed_plan [$];

  int   mismatch_count = 0;
  int   results_checked = 0;
  int   requests_sent = 0;
  int   status_seen [4];
  int   quiet_cycles = 0;
  logic sender_gaps = 1'b1;
  logic hold_request = 1'b0;

  function automatic slot_result_t apply_request(input desc_request_t r);
    slot_result_t res;
    int           limit;
    int           start;
    logic         in_range;
    logic         found;
    res.status = STAT_ERR;
    res.value  = SYS_NONE;
    limit      = (slot_limit < LIM_MAX) ? int'(slot_limit) : MAX_SLOTS;
    in_range   = int'(r.slot) < limit;
    case (r.op)
      OP_CHECK: begin
        if (in_range) res.status = STAT_OK;
      end
      OP_ASSOC: begin
        if (in_range && r.sys >= 0 && int'(r.sys) < SYSTEM_DESCRIPTORS) begin
          slot_binding[r.slot] = r.sys;
          res.status = STAT_OK;
          res.value  = r.sys;
        end
      end
      OP_LOOKUP: begin
        if (in_range && slot_binding[r.slot] >= 0) begin
          res.status = STAT_OK;
          res.value  = slot_binding[r.slot];
        end
      end
      OP_ALLOC_SPEC: begin
        if (!in_range) begin
          res.status = STAT_BADF;
        end else if (slot_binding[r.slot] >= 0) begin
          slot_binding[r.slot] = SYS_NONE;
          res.status = STAT_OK;
        end else if (slot_taken[r.slot]) begin
          res.status = STAT_BUSY;
        end else begin
          slot_taken[r.slot] = 1'b1;
          res.status = STAT_OK;
        end
      end
      OP_FREE: begin
        if (in_range) begin
          slot_taken[r.slot]   = 1'b0;
          slot_binding[r.slot] = SYS_NONE;
          res.status = STAT_OK;
        end
      end
      OP_DISASSOC: begin
        if (in_range && slot_binding[r.slot] >= 0) begin
          res.value = slot_binding[r.slot];
          if (int'(r.slot) >= RESERVED_SLOTS) slot_binding[r.slot] = SYS_NONE;
          res.status = STAT_OK;
        end
      end
      default: begin
        start = (int'(r.min_slot) < RESERVED_SLOTS) ? RESERVED_SLOTS : int'(r.min_slot);
        found = 1'b0;
        for (int i = start; i < limit; i++) begin
          if (!found && !slot_taken[i]) begin
            found = 1'b1;
            slot_taken[i] = 1'b1;
            if (r.op == OP_ALLOC_BIND) begin
              slot_binding[i] = (r.sys >= 0 && int'(r.sys) < SYSTEM_DESCRIPTORS) ?
                                r.sys : SYS_NONE;
            end
            res.status = STAT_OK;
            res.value  = sysd_t'(i);
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic plan_row_t request_row(input op_t op, input slot_t slot,
                                            input sysd_t sys, input slot_t min_slot);
    plan_row_t row;
    row = '0;
    row.req.op       = op;
    row.req.slot     = slot;
    row.req.sys      = sys;
    row.req.min_slot = min_slot;
    return row;
  endfunction

  function automatic plan_row_t known_row(input op_t op, input slot_t slot, input sysd_t sys,
                                          input slot_t min_slot, input status_t status,
                                          input sysd_t value);
    plan_row_t row;
    row = request_row(op, slot, sys, min_slot);
    row.known         = 1'b1;
    row.result.status = status;
    row.result.value  = value;
    return row;
  endfunction

  function automatic plan_row_t limit_row(input lim_t value);
    plan_row_t row;
    row = '0;
    row.is_limit = 1'b1;
    row.limit    = value;
    return row;
  endfunction

  task automatic offer_request(input desc_request_t r, input logic known,
                               input slot_result_t known_result);
    int           gap;
    int           pick;
    slot_result_t predicted;
    gap  = 0;
    pick = $urandom_range(0, 99);
    if (sender_gaps) begin
      if (pick >= 93) gap = $urandom_range(10, 40);
      else if (pick >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid             = 1'b1;
    in_ch.operation         = r.op;
    in_ch.slot_index        = r.slot;
    in_ch.system_descriptor = r.sys;
    in_ch.minimum_slot      = r.min_slot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = apply_request(r);
    pending_results.push_back(known ? known_result : predicted);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_results(input int settle);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_slot_limit(input lim_t value);
    wait_for_results(SETTLE_CYCLES);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we     = 1'b0;
    slot_limit = value;
  endtask

  always @(posedge clk) begin
    slot_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      status_seen[out_ch.status]++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d value %0d", $time,
                 out_ch.status, out_ch.descriptor_value);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_ch.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                   want.status, out_ch.status);
          mismatch_count++;
        end
        if (out_ch.descriptor_value !== want.value) begin
          $display("%0t: descriptor_value mismatch, expected %0d, actual %0d", $time,
                   want.value, out_ch.descriptor_value);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout after %0d cycles without a transfer.", quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The output side either runs free for a while or stalls; a requested hold
  // keeps ready low long enough for the block to back up into its input.
  initial begin
    int run;
    int stall;
    int pick;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ch.ready = 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      out_ch.ready = 1'b1;
      pick = $urandom_range(0, 99);
      run  = (pick < 10) ? $urandom_range(40, 120) : $urandom_range(1, 6);
      repeat (run) @(negedge clk);
      pick  = $urandom_range(0, 99);
      stall = 0;
      if (pick >= 92) stall = $urandom_range(15, 60);
      else if (pick >= 40) stall = $urandom_range(1, 3);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  initial begin
    desc_request_t r;
    lim_t          phase_limit;
    int            eff;
    int            pick;
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_wdata               = '0;
    in_ch.valid             = 1'b0;
    in_ch.operation         = OP_CHECK;
    in_ch.slot_index        = '0;
    in_ch.system_descriptor = SYS_NONE;
    in_ch.minimum_slot      = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      slot_taken[i]   = 1'b0;
      slot_binding[i] = SYS_NONE;
    end
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    slot_limit = LIM_MAX;

    directed_plan.push_back(known_row(OP_CHECK, 8'd0, SYS_NONE, 8'd0, STAT_OK, SYS_NONE));
    directed_plan.push_back(known_row(OP_LOOKUP, 8'd0, SYS_NONE, 8'd0, STAT_ERR, SYS_NONE));
    directed_plan.push_back(known_row(OP_ASSOC, 8'd0, SYS_NONE, 8'd0, STAT_ERR, SYS_NONE));
    directed_plan.push_back(known_row(OP_ASSOC, 8'd1, sysd_t'(-1024), 8'd0,
                                      STAT_ERR, SYS_NONE));
    directed_plan.push_back(known_row(OP_ASSOC, 8'd0, sysd_t'(1023), 8'd0,
                                      STAT_OK, sysd_t'(1023)));
    directed_plan.push_back(known_row(OP_DISASSOC, 8'd0, SYS_NONE, 8'd0,
                                      STAT_OK, sysd_t'(1023)));
    directed_plan.push_back(known_row(OP_LOOKUP, 8'd0, SYS_NONE, 8'd0,
                                      STAT_OK, sysd_t'(1023)));
    directed_plan.push_back(known_row(OP_ALLOC_SPEC, 8'd0, SYS_NONE, 8'd0, STAT_OK, SYS_NONE));
    directed_plan.push_back(known_row(OP_ALLOC_SPEC, 8'd0, SYS_NONE, 8'd0, STAT_OK, SYS_NONE));
    directed_plan.push_back(known_row(OP_ALLOC_SPEC, 8'd0, SYS_NONE, 8'd0,
                                      STAT_BUSY, SYS_NONE));
    directed_plan.push_back(known_row(OP_ALLOC_LOW, 8'd0, SYS_NONE, 8'd0,
                                      STAT_OK, sysd_t'(3)));
    directed_plan.push_back(known_row(OP_ALLOC_BIND, 8'd0, sysd_t'(0), 8'd255,
                                      STAT_OK, sysd_t'(255)));
    directed_plan.push_back(known_row(OP_ALLOC_BIND, 8'd0, sysd_t'(5), 8'd255,
                                      STAT_ERR, SYS_NONE));
    directed_plan.push_back(known_row(OP_DISASSOC, 8'd255, SYS_NONE, 8'd0,
                                      STAT_OK, sysd_t'(0)));
    directed_plan.push_back(known_row(OP_LOOKUP, 8'd255, SYS_NONE, 8'd0, STAT_ERR, SYS_NONE));
    directed_plan.push_back(request_row(OP_ALLOC_BIND, 8'd0, sysd_t'(-5), 8'd200));
    directed_plan.push_back(request_row(OP_LOOKUP, 8'd200, SYS_NONE, 8'd0));
    directed_plan.push_back(request_row(OP_FREE, 8'd255, SYS_NONE, 8'd0));
    directed_plan.push_back(limit_row(9'd5));
    directed_plan.push_back(known_row(OP_CHECK, 8'd4, SYS_NONE, 8'd0, STAT_OK, SYS_NONE));
    directed_plan.push_back(known_row(OP_CHECK, 8'd5, SYS_NONE, 8'd0, STAT_ERR, SYS_NONE));
    directed_plan.push_back(known_row(OP_ALLOC_SPEC, 8'd5, SYS_NONE, 8'd0,
                                      STAT_BADF, SYS_NONE));
    directed_plan.push_back(limit_row(9'd0));
    directed_plan.push_back(known_row(OP_CHECK, 8'd0, SYS_NONE, 8'd0, STAT_ERR, SYS_NONE));
    directed_plan.push_back(known_row(OP_ALLOC_LOW, 8'd0, SYS_NONE, 8'd0,
                                      STAT_ERR, SYS_NONE));
    directed_plan.push_back(limit_row(9'd511));
    directed_plan.push_back(known_row(OP_CHECK, 8'd255, SYS_NONE, 8'd0, STAT_OK, SYS_NONE));
    directed_plan.push_back(request_row(OP_ALLOC_LOW, 8'd0, SYS_NONE, 8'd254));

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_plan[n]) begin
      if (directed_plan[n].is_limit) begin
        write_slot_limit(directed_plan[n].limit);
      end else begin
        offer_request(directed_plan[n].req, directed_plan[n].known, directed_plan[n].result);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: phase_limit = LIM_MAX;
        1: phase_limit = lim_t'($urandom_range(4, 40));
        2: phase_limit = 9'd511;
        3: phase_limit = lim_t'($urandom_range(0, 511));
        default: phase_limit = lim_t'($urandom_range(8, 64));
      endcase
      write_slot_limit(phase_limit);
      eff = (phase_limit > LIM_MAX) ? MAX_SLOTS : int'(phase_limit);
      sender_gaps = (phase != 2);
      if (phase == 2) hold_request = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (phase == 3 && k == PHASE_ITEMS / 2) wait_for_results(0);
        r.op = op_t'($urandom_range(0, 7));
        pick = $urandom_range(0, 99);
        if (pick < 70) r.slot = slot_t'($urandom_range(0, 23));
        else if (pick < 90 && eff > 0) r.slot = slot_t'($urandom_range(0, eff - 1));
        else r.slot = slot_t'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 80) r.sys = sysd_t'($urandom_range(0, SYSTEM_DESCRIPTORS - 1));
        else if (pick < 90) r.sys = SYS_NONE;
        else r.sys = sysd_t'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 70) r.min_slot = slot_t'($urandom_range(0, 8));
        else if (pick < 90 && eff > 0) r.min_slot = slot_t'($urandom_range(0, eff - 1));
        else r.min_slot = slot_t'($urandom);
        offer_request(r, 1'b0, '0);
      end
    end

    wait_for_results(SETTLE_CYCLES);
    $display("Sent %0d requests over %0d slot-limit settings; checked %0d results.",
             requests_sent, PHASES + 3, results_checked);
    $display("Status mix ok/err/badf/busy: %0d/%0d/%0d/%0d, with a long output hold.",
             status_seen[STAT_OK], status_seen[STAT_ERR], status_seen[STAT_BADF],
             status_seen[STAT_BUSY]);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
